>>> hdl/sparse_score_top_k_select_defines.svh
// Assertion macros shared by the sparse score top-k select RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef SPARSE_SCORE_TOP_K_SELECT_DEFINES_SVH
`define SPARSE_SCORE_TOP_K_SELECT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked at every rising clock edge outside reset.
`define SSTKS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold outside reset.
`define SSTKS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SSTKS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSTKS_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> hdl/sstks_pkg.sv
// Shared widths, constants and structs of the sparse score top-k select block.
// No dependencies; every other RTL file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sstks_pkg;

    localparam int EX_W        = 16;
    localparam int CAND_W      = 16;
    localparam int ID_W        = 17;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 32;
    localparam int BIAS_W      = 32;
    localparam int SUM_W       = 40;
    localparam int SCORE_W     = 41;
    localparam int RANK_W      = 3;
    localparam int EMIT_MAX    = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One classified item as it waits in the queue.
    typedef struct packed {
        logic [EX_W-1:0]   example_id;
        logic [ID_W-1:0]   cand_p1;
        logic              insert;
        logic              has_term;
        logic [PROD_W-1:0] product;
        logic              close_cand;
        logic [BIAS_W-1:0] bias;
        logic              close_ex;
    } entry_t;

    // Item after the accumulator.
    typedef struct packed {
        logic [EX_W-1:0]   example_id;
        logic [ID_W-1:0]   cand_p1;
        logic              insert;
        logic              close_ex;
        logic [SUM_W-1:0]  sum;
        logic [BIAS_W-1:0] bias;
    } stage_a_t;

    // Item carrying its final score.
    typedef struct packed {
        logic [EX_W-1:0]    example_id;
        logic [ID_W-1:0]    cand_p1;
        logic               insert;
        logic               close_ex;
        logic [SCORE_W-1:0] score;
    } stage_b_t;

    // Ranking handed to the result stage; ids[0] is the best rank.
    typedef struct packed {
        logic                           valid;
        logic [EX_W-1:0]                example_id;
        logic [RANK_W-1:0]              count;
        logic [EMIT_MAX-1:0][ID_W-1:0]  ids;
    } emit_req_t;

endpackage

`default_nettype wire

>>> hdl/sstks_front.sv
// Front part: forms the product term and classifies each accepted item.
// Depends on sstks_pkg; writes into the queue in sstks_fifo.
`timescale 1ns / 1ps
`default_nettype none

module sstks_front #(
    parameter int NUM_CANDIDATES = 65536
) (
    input  wire logic [sstks_pkg::EX_W-1:0]         example_id,
    input  wire logic [sstks_pkg::CAND_W-1:0]       candidate,
    input  wire logic                               has_term,
    input  wire logic signed [sstks_pkg::VAL_W-1:0] feature_value,
    input  wire logic signed [sstks_pkg::VAL_W-1:0] weight,
    input  wire logic                               closes_candidate,
    input  wire logic [sstks_pkg::BIAS_W-1:0]       bias,
    input  wire logic                               closes_example,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               q_full,
    output logic                                    q_wr_en,
    output sstks_pkg::entry_t                       q_wr_data
);

    logic signed [sstks_pkg::PROD_W-1:0] product;
    logic                                in_range;

    assign product  = feature_value * weight;
    assign in_range = {1'b0, candidate} < sstks_pkg::ID_W'(NUM_CANDIDATES);

    always_comb
    begin
        q_wr_data.example_id = example_id;
        q_wr_data.cand_p1    = {1'b0, candidate} + sstks_pkg::ID_W'(1);
        // Out-of-range closes still clear the sum but never enter the list.
        q_wr_data.insert     = closes_candidate && in_range;
        q_wr_data.has_term   = has_term;
        q_wr_data.product    = product;
        q_wr_data.close_cand = closes_candidate;
        q_wr_data.bias       = bias;
        q_wr_data.close_ex   = closes_example;
    end

    assign q_wr_en = push;
    assign full    = q_full;

endmodule

`default_nettype wire

>>> hdl/sstks_fifo.sv
// Short queue between front and back parts of the top-k select block.
// Depends on sstks_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_score_top_k_select_defines.svh"

module sstks_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire sstks_pkg::entry_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output sstks_pkg::entry_t      rd_data,
    output logic                   empty
);

    localparam logic [sstks_pkg::QCNT_W-1:0] DEPTH_CNT =
        sstks_pkg::QCNT_W'(sstks_pkg::QUEUE_DEPTH);

    sstks_pkg::entry_t                 mem_reg [sstks_pkg::QUEUE_DEPTH];
    logic [sstks_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sstks_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sstks_pkg::QCNT_W-1:0]      count_reg;
    logic [sstks_pkg::QCNT_W-1:0]      count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full  = count_reg == DEPTH_CNT;
    assign empty = count_reg == '0;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + sstks_pkg::QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - sstks_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + sstks_pkg::QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + sstks_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];

    `SSTKS_NEVER(a_fifo_count, clk, rst_n, count_reg > DEPTH_CNT, "queue count above depth")

endmodule

`default_nettype wire

>>> hdl/sstks_back.sv
// Back part: saturating accumulator, bias add and sorted best-score list.
// Depends on sstks_pkg; reads sstks_fifo and feeds sstks_emit.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_score_top_k_select_defines.svh"

module sstks_back #(
    parameter int MAX_RANKS = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_data,
    input  wire logic              q_empty,
    input  wire sstks_pkg::entry_t q_data,
    output logic                   q_pop,
    input  wire logic              emit_ready,
    output sstks_pkg::emit_req_t   emit_req
);

    localparam int KEEP_N = (MAX_RANKS < sstks_pkg::EMIT_MAX) ? MAX_RANKS : sstks_pkg::EMIT_MAX;
    localparam int SW = sstks_pkg::SUM_W;
    localparam int CW = sstks_pkg::SCORE_W;
    localparam int IW = sstks_pkg::ID_W;

    logic                      keep_five_reg;
    logic [SW-1:0]             sum_reg;
    logic [SW-1:0]             sum_next;
    logic                      a_valid_reg;
    sstks_pkg::stage_a_t       a_reg;
    sstks_pkg::stage_a_t       a_next;
    logic                      b_valid_reg;
    sstks_pkg::stage_b_t       b_reg;
    sstks_pkg::stage_b_t       b_next;

    logic signed [CW-1:0]      score_reg [MAX_RANKS];
    logic [IW-1:0]             id_reg    [MAX_RANKS];
    logic [MAX_RANKS-1:0]      filled_reg;
    logic signed [CW-1:0]      score_next [MAX_RANKS];
    logic [IW-1:0]             id_next    [MAX_RANKS];
    logic [MAX_RANKS-1:0]      ins_filled;
    logic [MAX_RANKS-1:0]      filled_next;
    logic signed [CW-1:0]      prev_score [MAX_RANKS];
    logic [IW-1:0]             prev_id    [MAX_RANKS];
    logic [MAX_RANKS-1:0]      prev_filled;
    logic [MAX_RANKS-1:0]      beats;
    logic [MAX_RANKS-1:0]      beats_prev;
    logic [MAX_RANKS-1:0]      filled_inc;

    logic                      adv;
    logic                      take;
    logic [CW-1:0]             acc_wide;
    logic [SW-1:0]             sat_sum;
    logic [SW-1:0]             term_sum;

    // Hold the whole back part while a closing item waits for the result stage.
    assign adv   = !(b_valid_reg && b_reg.close_ex && !emit_ready);
    assign take  = adv && !q_empty;
    assign q_pop = take;

    // Accumulate with saturation to the 40-bit range.
    always_comb
    begin
        acc_wide = {sum_reg[SW-1], sum_reg}
                 + {{(CW - sstks_pkg::PROD_W){q_data.product[sstks_pkg::PROD_W-1]}}, q_data.product};
        if (acc_wide[CW-1] != acc_wide[CW-2])
        begin
            sat_sum = acc_wide[CW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sat_sum = acc_wide[SW-1:0];
        end
        term_sum = q_data.has_term ? sat_sum : sum_reg;

        sum_next = sum_reg;
        if (take)
        begin
            sum_next = (q_data.close_cand || q_data.close_ex) ? '0 : term_sum;
        end

        a_next.example_id = q_data.example_id;
        a_next.cand_p1    = q_data.cand_p1;
        a_next.insert     = q_data.insert;
        a_next.close_ex   = q_data.close_ex;
        a_next.sum        = term_sum;
        a_next.bias       = q_data.bias;
    end

    always_comb
    begin
        b_next.example_id = a_reg.example_id;
        b_next.cand_p1    = a_reg.cand_p1;
        b_next.insert     = a_reg.insert;
        b_next.close_ex   = a_reg.close_ex;
        b_next.score      = {a_reg.sum[SW-1], a_reg.sum}
                          + {{(CW - sstks_pkg::BIAS_W){a_reg.bias[sstks_pkg::BIAS_W-1]}}, a_reg.bias};
    end

    // Sorted insert: the list is descending with filled slots first, so the
    // slots the new score beats form a suffix; shift that suffix down one.
    always_comb
    begin
        prev_score[0] = score_reg[0];
        prev_id[0]    = id_reg[0];
        for (int i = 1; i < MAX_RANKS; i++)
        begin
            prev_score[i] = score_reg[i-1];
            prev_id[i]    = id_reg[i-1];
        end
        prev_filled = filled_reg << 1;

        for (int i = 0; i < MAX_RANKS; i++)
        begin
            beats[i] = !filled_reg[i] || ($signed(b_reg.score) > score_reg[i]);
        end
        beats_prev = beats << 1;

        for (int i = 0; i < MAX_RANKS; i++)
        begin
            score_next[i] = score_reg[i];
            id_next[i]    = id_reg[i];
            ins_filled[i] = filled_reg[i];
            if (b_reg.insert)
            begin
                if (beats_prev[i])
                begin
                    score_next[i] = prev_score[i];
                    id_next[i]    = prev_id[i];
                    ins_filled[i] = prev_filled[i];
                end
                else if (beats[i])
                begin
                    score_next[i] = $signed(b_reg.score);
                    id_next[i]    = b_reg.cand_p1;
                    ins_filled[i] = 1'b1;
                end
            end
        end

        filled_next = filled_reg;
        if (b_valid_reg && adv)
        begin
            filled_next = b_reg.close_ex ? '0 : ins_filled;
        end
    end

    always_comb
    begin
        emit_req.valid      = b_valid_reg && b_reg.close_ex;
        emit_req.example_id = b_reg.example_id;
        emit_req.count      = keep_five_reg ? sstks_pkg::RANK_W'(KEEP_N) : sstks_pkg::RANK_W'(1);
        emit_req.ids        = '0;
        for (int i = 0; i < KEEP_N; i++)
        begin
            emit_req.ids[i] = ins_filled[i] ? id_next[i] : '0;
        end
    end

    assign filled_inc = filled_reg + MAX_RANKS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_five_reg <= 1'b0;
            sum_reg       <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            filled_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                keep_five_reg <= cfg_data;
            end
            sum_reg    <= sum_next;
            filled_reg <= filled_next;
            if (adv)
            begin
                a_valid_reg <= !q_empty;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg <= a_next;
        end
        if (adv)
        begin
            b_reg <= b_next;
        end
        if (b_valid_reg && adv)
        begin
            score_reg <= score_next;
            id_reg    <= id_next;
        end
    end

    `SSTKS_ASSERT(a_back_prefix, clk, rst_n, (filled_inc & filled_reg) == '0, "not a prefix")
    `SSTKS_ASSERT(a_back_hold, clk, rst_n, !adv |=> (b_valid_reg && b_reg.close_ex), "close lost")

endmodule

`default_nettype wire

>>> hdl/sstks_emit.sv
// Result stage: holds one ranking and delivers it one rank per pop.
// Depends on sstks_pkg for the ranking struct.
`timescale 1ns / 1ps
`default_nettype none
`include "sparse_score_top_k_select_defines.svh"

module sstks_emit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sstks_pkg::emit_req_t         req,
    output logic                              ready,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [sstks_pkg::EX_W-1:0]        example_out,
    output logic [sstks_pkg::RANK_W-1:0]      rank,
    output logic [sstks_pkg::ID_W-1:0]        candidate_plus_one,
    output logic                              last
);

    logic                                                  busy_reg;
    logic [sstks_pkg::RANK_W-1:0]                          k_reg;
    logic [sstks_pkg::RANK_W-1:0]                          count_reg;
    logic [sstks_pkg::EX_W-1:0]                            ex_reg;
    logic [sstks_pkg::EMIT_MAX-1:0][sstks_pkg::ID_W-1:0]   ids_reg;
    logic                                                  take_out;
    logic                                                  load;

    assign last     = k_reg == (count_reg - sstks_pkg::RANK_W'(1));
    assign take_out = pop && busy_reg;
    // Take the next ranking in the same cycle the final rank leaves.
    assign ready    = !busy_reg || (take_out && last);
    assign load     = req.valid && ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (take_out)
            begin
                busy_reg <= !last;
                k_reg    <= k_reg + sstks_pkg::RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_reg <= req.count;
            ex_reg    <= req.example_id;
            ids_reg   <= req.ids;
        end
        else if (take_out)
        begin
            ids_reg <= ids_reg >> sstks_pkg::ID_W;
        end
    end

    assign empty              = !busy_reg;
    assign example_out        = ex_reg;
    assign rank               = k_reg;
    assign candidate_plus_one = ids_reg[0];

    `SSTKS_ASSERT(a_emit_rank, clk, rst_n, busy_reg |-> (k_reg < count_reg), "rank beyond count")
    `SSTKS_ASSERT(a_emit_drain, clk, rst_n, (take_out && last && !req.valid) |=> empty, "not drained")

endmodule

`default_nettype wire

>>> hdl/sparse_score_top_k_select.sv
// Sparse score top-k select: top level tying front, queue, back and result stage.
// Depends on sstks_pkg, sstks_front, sstks_fifo, sstks_back and sstks_emit.
//
// Usage:
//   Input is a queue write port: an item enters at a clock edge with push high
//   and full low. Each item carries at most one product term of a candidate;
//   closes_candidate adds the bias and ranks the candidate, closes_example
//   releases the ranking.
//   Results are a queue read port: while empty is low the oldest result sits on
//   example_out, rank, candidate_plus_one and last; pop high takes it.
//   cfg_valid/cfg_data write keep_five (cfg_ready is always high): 0 gives one
//   rank per example, 1 gives min(5, MAX_RANKS) ranks.
// Timing:
//   One item per cycle sustained while the result stage keeps up. An item passes
//   the queue, the accumulator stage and the score stage; the list update
//   follows, and with it the result stage takes a closing item's ranking.
//   Results leave one per cycle while pop is high; a second closing item waits
//   at the list stage until the result stage has taken the previous ranking's
//   final rank, and the queue backs up. If pop stays low, results hold and full
//   rises once the four-entry queue fills.
// Reset: clears queue, running sum, list and keep_five; no results pending.
`timescale 1ns / 1ps
`default_nettype none

module sparse_score_top_k_select #(
    parameter int MAX_RANKS      = 5,
    parameter int NUM_CANDIDATES = 65536
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic                               cfg_data,
    input  wire logic [sstks_pkg::EX_W-1:0]         example_id,
    input  wire logic [sstks_pkg::CAND_W-1:0]       candidate,
    input  wire logic                               has_term,
    input  wire logic signed [sstks_pkg::VAL_W-1:0] feature_value,
    input  wire logic signed [sstks_pkg::VAL_W-1:0] weight,
    input  wire logic                               closes_candidate,
    input  wire logic signed [sstks_pkg::BIAS_W-1:0] bias,
    input  wire logic                               closes_example,
    input  wire logic                               push,
    output logic                                    full,
    output logic [sstks_pkg::EX_W-1:0]              example_out,
    output logic [sstks_pkg::RANK_W-1:0]            rank,
    output logic [sstks_pkg::ID_W-1:0]              candidate_plus_one,
    output logic                                    last,
    output logic                                    empty,
    input  wire logic                               pop
);

    logic                  q_full;
    logic                  q_wr_en;
    sstks_pkg::entry_t     q_wr_data;
    logic                  q_empty;
    logic                  q_pop;
    sstks_pkg::entry_t     q_rd_data;
    logic                  emit_ready;
    sstks_pkg::emit_req_t  emit_req;

    assign cfg_ready = 1'b1;

    sstks_front #(
        .NUM_CANDIDATES (NUM_CANDIDATES)
    ) u_front (
        .example_id       (example_id),
        .candidate        (candidate),
        .has_term         (has_term),
        .feature_value    (feature_value),
        .weight           (weight),
        .closes_candidate (closes_candidate),
        .bias             (bias),
        .closes_example   (closes_example),
        .push             (push),
        .full             (full),
        .q_full           (q_full),
        .q_wr_en          (q_wr_en),
        .q_wr_data        (q_wr_data)
    );

    sstks_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    sstks_back #(
        .MAX_RANKS (MAX_RANKS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .q_empty    (q_empty),
        .q_data     (q_rd_data),
        .q_pop      (q_pop),
        .emit_ready (emit_ready),
        .emit_req   (emit_req)
    );

    sstks_emit u_emit (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (emit_req),
        .ready              (emit_ready),
        .empty              (empty),
        .pop                (pop),
        .example_out        (example_out),
        .rank               (rank),
        .candidate_plus_one (candidate_plus_one),
        .last               (last)
    );

endmodule

`default_nettype wire

>>> bench/rank_check_pkg.sv
// Item and result types, rank mode codes and the top-k score list predictor
// used by the sparse score top-k select bench. Depends on sstks_pkg only.
`timescale 1ns / 1ps

package rank_check_pkg;

    localparam int     LIST_DEPTH = 5;
    localparam int     CAND_LIMIT = 65536;
    localparam longint SUM_HI     = (longint'(1) << (sstks_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_LO     = -(longint'(1) << (sstks_pkg::SUM_W - 1));

    typedef enum logic {
        KEEP_ONE  = 1'b0,
        KEEP_FIVE = 1'b1
    } rank_mode_e;

    typedef struct {
        logic [sstks_pkg::EX_W-1:0]          example_id;
        logic [sstks_pkg::CAND_W-1:0]        candidate;
        logic                                has_term;
        logic signed [sstks_pkg::VAL_W-1:0]  feature_value;
        logic signed [sstks_pkg::VAL_W-1:0]  weight;
        logic                                closes_candidate;
        logic signed [sstks_pkg::BIAS_W-1:0] bias;
        logic                                closes_example;
    } term_item_t;

    typedef struct {
        logic [sstks_pkg::EX_W-1:0]   example_out;
        logic [sstks_pkg::RANK_W-1:0] rank;
        logic [sstks_pkg::ID_W-1:0]   candidate_plus_one;
        logic                         last;
    } rank_result_t;

    class ranking_checker;

        rank_mode_e                 mode;
        longint                     running_sum;
        longint                     scores[LIST_DEPTH];
        logic [sstks_pkg::ID_W-1:0] ids[LIST_DEPTH];
        bit                         filled[LIST_DEPTH];
        rank_result_t               expected_ranks[$];
        int                         mismatches;

        function new();
            mode        = KEEP_ONE;
            running_sum = 0;
            mismatches  = 0;
            clear_list();
        endfunction

        function void clear_list();
            for (int n = 0; n < LIST_DEPTH; n++)
            begin
                scores[n] = 0;
                ids[n]    = '0;
                filled[n] = 1'b0;
            end
        endfunction

        // Strict compare: on a tie the earlier candidate holds its rank.
        function void insert_score(longint score, logic [sstks_pkg::ID_W-1:0] id);
            int p;
            p = 0;
            while (p < LIST_DEPTH && filled[p] && !(score > scores[p]))
                p++;
            if (p >= LIST_DEPTH)
                return;
            for (int n = LIST_DEPTH - 1; n > p; n--)
            begin
                scores[n] = scores[n - 1];
                ids[n]    = ids[n - 1];
                filled[n] = filled[n - 1];
            end
            scores[p] = score;
            ids[p]    = id;
            filled[p] = 1'b1;
        endfunction

        function int pending();
            return expected_ranks.size();
        endfunction

        // Term first, then the candidate close, then the example close.
        function void accept_item(term_item_t it);
            longint       sum;
            rank_result_t r;
            int           shown;
            if (it.has_term)
            begin
                sum = running_sum + longint'(it.feature_value) * longint'(it.weight);
                running_sum = (sum > SUM_HI) ? SUM_HI : (sum < SUM_LO) ? SUM_LO : sum;
            end
            if (it.closes_candidate)
            begin
                if (int'(it.candidate) < CAND_LIMIT)
                    insert_score(running_sum + longint'(it.bias),
                                 {1'b0, it.candidate} + sstks_pkg::ID_W'(1));
                running_sum = 0;
            end
            if (it.closes_example)
            begin
                shown = 1;
                if (mode == KEEP_FIVE)
                    shown = (LIST_DEPTH < sstks_pkg::EMIT_MAX) ? LIST_DEPTH : sstks_pkg::EMIT_MAX;
                for (int k = 0; k < shown; k++)
                begin
                    r.example_out        = it.example_id;
                    r.rank               = sstks_pkg::RANK_W'(k);
                    r.candidate_plus_one = filled[k] ? ids[k] : '0;
                    r.last               = (k == shown - 1);
                    expected_ranks.push_back(r);
                end
                clear_list();
                running_sum = 0;
            end
        endfunction

        function void check_field(string field, logic [sstks_pkg::ID_W-1:0] want,
                                  logic [sstks_pkg::ID_W-1:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_rank(rank_result_t got);
            rank_result_t want;
            if (expected_ranks.size() == 0)
            begin
                $error("result with no ranking waiting: example_out %0d rank %0d",
                       got.example_out, got.rank);
                mismatches++;
                return;
            end
            want = expected_ranks.pop_front();
            check_field("example_out", want.example_out, got.example_out);
            check_field("rank", want.rank, got.rank);
            check_field("candidate_plus_one", want.candidate_plus_one,
                        got.candidate_plus_one);
            check_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

>>> bench/testbench.sv
// Bench top for sparse_score_top_k_select: drives term items and mode writes,
// drains ranked results and checks them. Depends on sstks_pkg and rank_check_pkg.
`timescale 1ns / 1ps

module testbench;

    logic                                clk              = 1'b0;
    logic                                rst_n            = 1'b0;
    logic                                cfg_valid        = 1'b0;
    logic                                cfg_ready;
    logic                                cfg_data         = 1'b0;
    logic [sstks_pkg::EX_W-1:0]          example_id       = '0;
    logic [sstks_pkg::CAND_W-1:0]        candidate        = '0;
    logic                                has_term         = 1'b0;
    logic signed [sstks_pkg::VAL_W-1:0]  feature_value    = '0;
    logic signed [sstks_pkg::VAL_W-1:0]  weight           = '0;
    logic                                closes_candidate = 1'b0;
    logic signed [sstks_pkg::BIAS_W-1:0] bias             = '0;
    logic                                closes_example   = 1'b0;
    logic                                push             = 1'b0;
    logic                                full;
    logic [sstks_pkg::EX_W-1:0]          example_out;
    logic [sstks_pkg::RANK_W-1:0]        rank;
    logic [sstks_pkg::ID_W-1:0]          candidate_plus_one;
    logic                                last;
    logic                                empty;
    logic                                pop              = 1'b0;

    rank_check_pkg::ranking_checker ranking = new();

    int items_sent   = 0;
    int long_items   = 0;
    int results_seen = 0;
    int mode_writes  = 0;
    bit steady       = 1'b0;
    bit hold_results = 1'b0;

    sparse_score_top_k_select #(
        .MAX_RANKS      (rank_check_pkg::LIST_DEPTH),
        .NUM_CANDIDATES (rank_check_pkg::CAND_LIMIT)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .example_id         (example_id),
        .candidate          (candidate),
        .has_term           (has_term),
        .feature_value      (feature_value),
        .weight             (weight),
        .closes_candidate   (closes_candidate),
        .bias               (bias),
        .closes_example     (closes_example),
        .push               (push),
        .full               (full),
        .example_out        (example_out),
        .rank               (rank),
        .candidate_plus_one (candidate_plus_one),
        .last               (last),
        .empty              (empty),
        .pop                (pop)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic rank_check_pkg::term_item_t make_item(
        input logic [sstks_pkg::EX_W-1:0] ex, input logic [sstks_pkg::CAND_W-1:0] cand,
        input bit term, input logic signed [sstks_pkg::VAL_W-1:0] fv,
        input logic signed [sstks_pkg::VAL_W-1:0] w, input bit close_cand,
        input logic signed [sstks_pkg::BIAS_W-1:0] b, input bit close_ex);
        rank_check_pkg::term_item_t it;
        it.example_id       = ex;
        it.candidate        = cand;
        it.has_term         = term;
        it.feature_value    = fv;
        it.weight           = w;
        it.closes_candidate = close_cand;
        it.bias             = b;
        it.closes_example   = close_ex;
        return it;
    endfunction

    function automatic logic signed [sstks_pkg::VAL_W-1:0] pick_q412();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [sstks_pkg::BIAS_W-1:0] pick_bias();
        case ($urandom_range(0, 5))
            0:       return 32'sh80000000;
            1:       return 32'sh7fffffff;
            2:       return 32'($urandom_range(0, 8)) - 32'sd4;
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic logic [sstks_pkg::CAND_W-1:0] pick_cand();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Hold push and the fields until full is seen low at an edge.
    task automatic offer(input rank_check_pkg::term_item_t it);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        example_id       <= it.example_id;
        candidate        <= it.candidate;
        has_term         <= it.has_term;
        feature_value    <= it.feature_value;
        weight           <= it.weight;
        closes_candidate <= it.closes_candidate;
        bias             <= it.bias;
        closes_example   <= it.closes_example;
        push             <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        ranking.accept_item(it);
        items_sent++;
    endtask

    task automatic send_run(input logic [sstks_pkg::EX_W-1:0] ex,
                            input logic [sstks_pkg::CAND_W-1:0] cand,
                            input int count, input logic signed [sstks_pkg::VAL_W-1:0] fv,
                            input logic signed [sstks_pkg::VAL_W-1:0] w);
        repeat (count)
            offer(make_item(ex, cand, 1'b1, fv, w, 1'b0, '0, 1'b0));
    endtask

    // Well-formed example with random content; now and then left open.
    task automatic send_example();
        logic [sstks_pkg::EX_W-1:0]          ex;
        logic [sstks_pkg::CAND_W-1:0]        cand;
        logic signed [sstks_pkg::BIAS_W-1:0] b;
        int                                  n_cand;
        int                                  c;
        bit                                  ties;
        bit                                  close_here;
        ex     = 16'($urandom);
        n_cand = $urandom_range(0, 8);
        ties   = ($urandom_range(0, 3) == 0);
        for (c = 0; c < n_cand; c++)
        begin
            cand = pick_cand();
            if (!ties)
                repeat ($urandom_range(0, 3))
                    offer(make_item(ex, cand, 1'b1, pick_q412(), pick_q412(),
                                    1'b0, '0, 1'b0));
            b          = ties ? 32'($urandom_range(0, 2)) : pick_bias();
            close_here = (c == n_cand - 1) && ($urandom_range(0, 1) == 1);
            offer(make_item(ex, cand, !ties && ($urandom_range(0, 1) == 1),
                            pick_q412(), pick_q412(), 1'b1, b, close_here));
            if (close_here || $urandom_range(0, 19) == 0)
                return;
        end
        // Leave a candidate open now and then; the example close drops its terms.
        if ($urandom_range(0, 3) == 0)
            offer(make_item(ex, pick_cand(), 1'b1, pick_q412(), pick_q412(),
                            1'b0, '0, 1'b0));
        offer(make_item(ex, pick_cand(), $urandom_range(0, 1) == 1, pick_q412(),
                        pick_q412(), 1'b0, pick_bias(), 1'b1));
    endtask

    // Stop offering until every ranking is out, then let trailing items clear.
    task automatic settle();
        push <= 1'b0;
        while (ranking.pending() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);
    endtask

    task automatic write_mode(input rank_check_pkg::rank_mode_e m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ranking.mode = m;
        mode_writes++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            ranking.check_rank('{example_out, rank, candidate_plus_one, last});
            results_seen++;
        end
    end

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                hold_left    = 200;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    initial
    begin : item_side
        int phase;
        int phase_start;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(rank_check_pkg::KEEP_FIVE);

        // Empty list, then one item that adds, closes the candidate and the example.
        offer(make_item(16'd0, 16'd0, 1'b0, '0, '0, 1'b0, '0, 1'b1));
        offer(make_item(16'hffff, 16'hffff, 1'b1, 16'sh8000, 16'sh8000, 1'b1,
                        32'sh7fffffff, 1'b1));
        offer(make_item(16'd1, 16'd0, 1'b1, 16'sh7fff, 16'sh7fff, 1'b1,
                        32'sh80000000, 1'b0));
        offer(make_item(16'd1, 16'd7, 1'b0, '0, '0, 1'b1, 32'sd100, 1'b0));
        offer(make_item(16'd1, 16'd8, 1'b0, '0, '0, 1'b1, 32'sd100, 1'b0));
        // Values without has_term add nothing.
        offer(make_item(16'd1, 16'd9, 1'b0, 16'sh7fff, 16'sh7fff, 1'b1, 32'sd100, 1'b0));
        offer(make_item(16'd1, 16'd10, 1'b0, '0, '0, 1'b1, -32'sd5, 1'b0));
        offer(make_item(16'd1, 16'd11, 1'b0, '0, '0, 1'b1, 32'sd200, 1'b0));
        offer(make_item(16'd1, 16'd12, 1'b0, '0, '0, 1'b1, -32'sd1000, 1'b0));
        offer(make_item(16'd1, 16'd13, 1'b1, 16'sh8000, 16'sh7fff, 1'b0, '0, 1'b0));
        offer(make_item(16'd1, 16'd13, 1'b1, 16'sd5, 16'sd5, 1'b0, '0, 1'b1));
        offer(make_item(16'd2, 16'd3, 1'b0, '0, '0, 1'b1, '0, 1'b0));
        offer(make_item(16'd2, 16'd0, 1'b0, '0, '0, 1'b0, '0, 1'b1));

        // Run the largest terms back to back with no idling on either side.
        steady     = 1'b1;
        long_items = items_sent;
        send_run(16'd40, 16'd30, 12, 16'sh8000, 16'sh8000);
        send_run(16'd40, 16'd30, 10, 16'sh8000, 16'sh7fff);
        offer(make_item(16'd40, 16'd30, 1'b0, '0, '0, 1'b1, '0, 1'b0));
        offer(make_item(16'd40, 16'd31, 1'b0, '0, '0, 1'b1, '0, 1'b0));
        send_run(16'd40, 16'd33, 6, 16'sh8000, 16'sh8000);
        offer(make_item(16'd40, 16'd33, 1'b0, '0, '0, 1'b1, '0, 1'b1));
        long_items = items_sent - long_items;
        steady     = 1'b0;

        // Switch the mode while an example is open.
        offer(make_item(16'd3, 16'd20, 1'b1, 16'sd4096, 16'sd4096, 1'b1, '0, 1'b0));
        offer(make_item(16'd3, 16'd21, 1'b0, '0, '0, 1'b1, 32'sd1, 1'b0));
        settle();
        write_mode(rank_check_pkg::KEEP_ONE);
        offer(make_item(16'd3, 16'd22, 1'b0, '0, '0, 1'b1, -32'sd1, 1'b1));

        for (phase = 0; phase < 6; phase++)
        begin
            steady = (phase == 3);
            // Stall the result side while items keep coming, so full rises.
            if (phase == 1)
                hold_results = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < 36)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_example();
                else
                    offer(make_item(16'($urandom), 16'($urandom),
                                    $urandom_range(0, 1) == 1, pick_q412(), pick_q412(),
                                    $urandom_range(0, 1) == 1, pick_bias(),
                                    $urandom_range(0, 3) == 0));
            end
            settle();
            if (phase < 5)
                write_mode((phase % 2 == 0) ? rank_check_pkg::KEEP_FIVE
                                            : rank_check_pkg::KEEP_ONE);
        end

        $display("Run covered %0d items (%0d back to back with large terms) and %0d results",
                 items_sent, long_items, results_seen);
        $display("over %0d mode writes, with %0d result mismatches.",
                 mode_writes, ranking.mismatches);
        if (ranking.mismatches == 0 && ranking.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
